// File: hdl/gb2312_glyph_locator_defines.svh
// Assertion macros used by the glyph locator checker.
`ifndef GB2312_GLYPH_LOCATOR_DEFINES_SVH
`define GB2312_GLYPH_LOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GBGL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbgl: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GBGL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbgl: next-cycle check failed");

`endif

// File: hdl/gbgl_pkg.sv
`default_nettype none

package gbgl_pkg;

    localparam int CODE_W   = 16;
    localparam int ASCII_W  = 7;
    localparam int IDX_W    = 13;
    localparam int OFFSET_W = 18;
    localparam int WIDTH_W  = 5;
    localparam int SRC_W    = 2;
    localparam int CFG_IDX_W = 1;

    // Glyph storage sizes and extension font population
    localparam int NARROW_GLYPH_BYTES = 16;
    localparam int WIDE_GLYPH_BYTES   = 32;
    localparam int EXTRA_GLYPH_COUNT  = 30;

    localparam int EXTRA_LIST_LEN = 30;
    localparam int EXTRA_SEARCH   = (EXTRA_GLYPH_COUNT < EXTRA_LIST_LEN) ?
                                    EXTRA_GLYPH_COUNT : EXTRA_LIST_LEN;

    // GB2312 code space
    localparam logic [CODE_W-1:0] HANZI_FIRST = 16'h80A0;
    localparam logic [7:0] ROW_FIRST = 8'hB0;
    localparam logic [7:0] ROW_LAST  = 8'hF7;
    localparam logic [7:0] COL_FIRST = 8'hA1;
    localparam logic [7:0] COL_LAST  = 8'hFE;
    localparam int ROW_GLYPHS = 94;

    localparam logic [ASCII_W-1:0] ASCII_FIRST_RST = 7'h20;
    localparam logic [ASCII_W-1:0] ASCII_LAST_RST  = 7'h7E;

    localparam logic [WIDTH_W-1:0] NARROW_PIXELS = 5'd8;
    localparam logic [WIDTH_W-1:0] WIDE_PIXELS   = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ASCII_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ASCII_LAST  = 1'b1;

    typedef enum logic [SRC_W-1:0] {
        SRC_BLANK  = 2'd0,
        SRC_NARROW = 2'd1,
        SRC_MAIN   = 2'd2,
        SRC_EXTRA  = 2'd3
    } glyph_src_t;

    // Punctuation codes held in the extension font, in glyph order
    localparam logic [CODE_W-1:0] EXTRA_CODES [EXTRA_LIST_LEN] = '{
        16'hA1A2, 16'hA1A3, 16'hA1AA, 16'hA1AD, 16'hA1AE, 16'hA1AF, 16'hA1B0, 16'hA1B1,
        16'hA1B2, 16'hA1B3, 16'hA1B4, 16'hA1B5, 16'hA1B6, 16'hA1B7, 16'hA1B8, 16'hA1B9,
        16'hA1BA, 16'hA1BB, 16'hA1BE, 16'hA1BF, 16'hA3A1, 16'hA3A8, 16'hA3A9, 16'hA3AC,
        16'hA3AD, 16'hA3AE, 16'hA3BA, 16'hA3BB, 16'hA3BF, 16'hE0C5
    };

    // Lookup result before the offset multiply
    typedef struct packed {
        glyph_src_t       src;
        logic [IDX_W-1:0] idx;
        logic             wide;
    } glyph_loc_t;

endpackage

`default_nettype wire

// File: hdl/gbgl_index.sv
`default_nettype none

// Classify one character code and compute its glyph number.
module gbgl_index (
    input  wire logic [gbgl_pkg::CODE_W-1:0]  code,
    input  wire logic [gbgl_pkg::ASCII_W-1:0] ascii_first,
    input  wire logic [gbgl_pkg::ASCII_W-1:0] ascii_last,
    output gbgl_pkg::glyph_loc_t              loc
);

    logic [7:0] hi;
    logic [7:0] lo;
    logic       hanzi;
    logic       main_hit;
    logic       narrow_hit;
    logic [6:0] row;
    logic [6:0] col;
    logic       extra_hit;
    logic [gbgl_pkg::IDX_W-1:0] extra_idx;

    assign hi    = code[15:8];
    assign lo    = code[7:0];
    assign hanzi = (code >= gbgl_pkg::HANZI_FIRST);

    assign main_hit = hanzi
                    && (hi >= gbgl_pkg::ROW_FIRST) && (hi <= gbgl_pkg::ROW_LAST)
                    && (lo >= gbgl_pkg::COL_FIRST) && (lo <= gbgl_pkg::COL_LAST);

    assign row = 7'(hi - gbgl_pkg::ROW_FIRST);
    assign col = 7'(lo - gbgl_pkg::COL_FIRST);

    assign narrow_hit = !hanzi
                      && (code >= {9'd0, ascii_first})
                      && (code <= {9'd0, ascii_last});

    // Parallel compare against the punctuation list; first match wins
    always_comb
    begin
        extra_hit = 1'b0;
        extra_idx = '0;
        for (int p = 0; p < gbgl_pkg::EXTRA_SEARCH; p++)
        begin
            if (!extra_hit && (code == gbgl_pkg::EXTRA_CODES[p]))
            begin
                extra_hit = 1'b1;
                extra_idx = gbgl_pkg::IDX_W'(p);
            end
        end
    end

    always_comb
    begin
        loc.wide = hanzi;
        if (main_hit)
        begin
            loc.src = gbgl_pkg::SRC_MAIN;
            loc.idx = gbgl_pkg::IDX_W'({25'd0, row} * gbgl_pkg::ROW_GLYPHS + {25'd0, col});
        end
        else if (hanzi && extra_hit)
        begin
            loc.src = gbgl_pkg::SRC_EXTRA;
            loc.idx = extra_idx;
        end
        else if (narrow_hit)
        begin
            loc.src = gbgl_pkg::SRC_NARROW;
            loc.idx = gbgl_pkg::IDX_W'(7'(code[6:0] - ascii_first));
        end
        else
        begin
            loc.src = gbgl_pkg::SRC_BLANK;
            loc.idx = '0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/gb2312_glyph_locator.sv
// Glyph locator for a GB2312 text renderer.
// Input stream (s_*): one 16-bit character code per transfer in s_tdata.
//   Codes from 0x80A0 up are GB2312 high:low byte pairs, lower codes are ASCII.
// Output stream (m_*): one result per input code, in order. m_tuser carries the
//   font source (0 blank, 1 narrow 8x16, 2 main hanzi, 3 punctuation extension);
//   m_tdata carries glyph index, byte offset into that font and pixel width.
// Config channel (cfg_*): cfg_index 0 writes ascii_first, 1 writes ascii_last
//   (7 bits each). Always ready; write only while no codes are in flight.
// Pipeline: two register stages, code then result; an accepted code waits in
//   the code stage until the result stage can take its located glyph.
// Throughput: one code per cycle while m_tready is high; the stages advance
//   independently, so bubbles collapse and an empty code stage still takes a
//   code while a result waits. Stall: with m_tready low the result holds;
//   s_tready drops only once both stages hold an item.
// Reset: clears all valid bits and restores ascii_first = 0x20 and
//   ascii_last = 0x7E; the block takes codes from the first edge after reset.
`default_nettype none

module gb2312_glyph_locator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] char_code
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [39:0] m_tdata,    // [12:0] glyph_index, [30:13] byte_offset,
                                         // [35:31] glyph_width, [39:36] zero
    output      logic [1:0]  m_tuser,    // [1:0] glyph_source
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    // Configuration registers
    logic [gbgl_pkg::ASCII_W-1:0] ascii_first_reg, ascii_first_next;
    logic [gbgl_pkg::ASCII_W-1:0] ascii_last_reg,  ascii_last_next;

    // Stage 1: accepted code
    logic                        code_vld_reg, code_vld_next;
    logic [gbgl_pkg::CODE_W-1:0] code_reg,     code_next;

    // Located glyph of the held code
    gbgl_pkg::glyph_loc_t loc_comb;

    // Stage 2: result
    logic                          res_vld_reg,    res_vld_next;
    gbgl_pkg::glyph_src_t          res_src_reg,    res_src_next;
    logic [gbgl_pkg::IDX_W-1:0]    res_idx_reg,    res_idx_next;
    logic [gbgl_pkg::OFFSET_W-1:0] res_offset_reg, res_offset_next;
    logic [gbgl_pkg::WIDTH_W-1:0]  res_width_reg,  res_width_next;

    logic adv_code;
    logic adv_res;

    // A stage moves on when it is empty or its content moves downstream
    assign adv_res  = !res_vld_reg || m_tready;
    assign adv_code = !code_vld_reg || adv_res;

    assign s_tready  = adv_code;
    assign cfg_ready = 1'b1;

    // Decode config writes
    always_comb
    begin
        ascii_first_next = ascii_first_reg;
        ascii_last_next  = ascii_last_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                gbgl_pkg::REG_ASCII_FIRST: ascii_first_next = cfg_data;
                gbgl_pkg::REG_ASCII_LAST:  ascii_last_next  = cfg_data;
                default: ;
            endcase
        end
    end

    gbgl_index u_index (
        .code        (code_reg),
        .ascii_first (ascii_first_reg),
        .ascii_last  (ascii_last_reg),
        .loc         (loc_comb)
    );

    // Advance each stage's valid bit and payload
    always_comb
    begin
        code_vld_next = code_vld_reg;
        code_next     = code_reg;
        if (adv_code)
        begin
            code_vld_next = s_tvalid;
            code_next     = s_tdata;
        end

        res_vld_next    = res_vld_reg;
        res_src_next    = res_src_reg;
        res_idx_next    = res_idx_reg;
        res_offset_next = res_offset_reg;
        res_width_next  = res_width_reg;
        if (adv_res)
        begin
            res_vld_next = code_vld_reg;
            res_src_next = loc_comb.src;
            res_idx_next = loc_comb.idx;
            // Offset wraps at 18 bits; a blank glyph carries index zero
            if (loc_comb.wide)
            begin
                res_offset_next = gbgl_pkg::OFFSET_W'(
                    {19'd0, loc_comb.idx} * gbgl_pkg::WIDE_GLYPH_BYTES);
                res_width_next  = gbgl_pkg::WIDE_PIXELS;
            end
            else
            begin
                res_offset_next = gbgl_pkg::OFFSET_W'(
                    {19'd0, loc_comb.idx} * gbgl_pkg::NARROW_GLYPH_BYTES);
                res_width_next  = gbgl_pkg::NARROW_PIXELS;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ascii_first_reg <= gbgl_pkg::ASCII_FIRST_RST;
            ascii_last_reg  <= gbgl_pkg::ASCII_LAST_RST;
            code_vld_reg    <= 1'b0;
            res_vld_reg     <= 1'b0;
        end
        else
        begin
            ascii_first_reg <= ascii_first_next;
            ascii_last_reg  <= ascii_last_next;
            code_vld_reg    <= code_vld_next;
            res_vld_reg     <= res_vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        code_reg       <= code_next;
        res_src_reg    <= res_src_next;
        res_idx_reg    <= res_idx_next;
        res_offset_reg <= res_offset_next;
        res_width_reg  <= res_width_next;
    end

    assign m_tvalid = res_vld_reg;
    assign m_tuser  = res_src_reg;
    assign m_tdata  = {4'd0, res_width_reg, res_offset_reg, res_idx_reg};

endmodule

`default_nettype wire

// File: hdl/gbgl_checker.sv
`default_nettype none
`include "gb2312_glyph_locator_defines.svh"

// Port-level checks on the glyph locator.
module gbgl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [0:0]  cfg_index,
    input wire logic [6:0]  cfg_data
);

    logic        src_blank;
    logic        src_narrow;
    logic        src_wide;
    logic [12:0] idx;
    logic [17:0] offset;
    logic [4:0]  width;
    logic        unused;

    assign src_blank  = (m_tuser == gbgl_pkg::SRC_BLANK);
    assign src_narrow = (m_tuser == gbgl_pkg::SRC_NARROW);
    assign src_wide   = (m_tuser == gbgl_pkg::SRC_MAIN) || (m_tuser == gbgl_pkg::SRC_EXTRA);
    assign idx    = m_tdata[12:0];
    assign offset = m_tdata[30:13];
    assign width  = m_tdata[35:31];
    assign unused = ^{s_tvalid, s_tready, s_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

    `GBGL_ASSERT_NOW(a_blank_zero, clk, rst_n, m_tvalid && src_blank,
        (idx == '0) && (offset == '0))
    `GBGL_ASSERT_NOW(a_wide_glyph, clk, rst_n, m_tvalid && src_wide,
        (width == gbgl_pkg::WIDE_PIXELS)
        && (offset == 18'({19'd0, idx} * gbgl_pkg::WIDE_GLYPH_BYTES)))
    `GBGL_ASSERT_NOW(a_narrow_glyph, clk, rst_n, m_tvalid && src_narrow,
        (width == gbgl_pkg::NARROW_PIXELS)
        && (offset == 18'({19'd0, idx} * gbgl_pkg::NARROW_GLYPH_BYTES)))
    `GBGL_ASSERT_NEXT(a_hold_stalled, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind gb2312_glyph_locator gbgl_checker u_gbgl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

`default_nettype wire

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbgl_pkg::*;

    // One located glyph as it leaves the block.
    typedef struct {
        glyph_src_t  glyph_src;
        logic [12:0] glyph_idx;
        logic [17:0] byte_off;
        logic [4:0]  pix_width;
    } glyph_result_t;

    // One row of the directed stimulus; typed rows carry a hand-read result.
    typedef struct {
        logic [15:0]   code;
        bit            typed;
        glyph_result_t result;
    } code_row_t;

    // Punctuation codes of the extension font, in glyph order.
    localparam logic [15:0] PUNCT_TABLE [30] = '{
        16'hA1A2, 16'hA1A3, 16'hA1AA, 16'hA1AD, 16'hA1AE, 16'hA1AF, 16'hA1B0, 16'hA1B1,
        16'hA1B2, 16'hA1B3, 16'hA1B4, 16'hA1B5, 16'hA1B6, 16'hA1B7, 16'hA1B8, 16'hA1B9,
        16'hA1BA, 16'hA1BB, 16'hA1BE, 16'hA1BF, 16'hA3A1, 16'hA3A8, 16'hA3A9, 16'hA3AC,
        16'hA3AD, 16'hA3AE, 16'hA3BA, 16'hA3BB, 16'hA3BF, 16'hE0C5
    };
    localparam int PUNCT_SEARCH = (EXTRA_GLYPH_COUNT < 30) ? EXTRA_GLYPH_COUNT : 30;

    localparam int RANDOM_PHASES    = 8;
    localparam int CODES_PER_PHASE  = 100;
    localparam int SETTLE_CYCLES    = 6;
    localparam int DIRECTED_ROWS    = 24;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;

    // Shadow copy of the narrow font range registers.
    logic [6:0] range_first = ASCII_FIRST_RST;
    logic [6:0] range_last  = ASCII_LAST_RST;

    // Glyphs predicted for accepted codes, oldest first.
    glyph_result_t pending_glyphs [$];
    glyph_result_t oldest_glyph;

    int  error_count = 0;
    int  codes_sent  = 0;
    int  config_writes = 0;
    int  source_hits [4] = '{0, 0, 0, 0};
    bit  no_idle = 1'b0;
    int  ready_hold = 0;

    gb2312_glyph_locator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Locate the glyph of one character code under the current range setting.
    function automatic glyph_result_t locate_glyph(input logic [15:0] code);
        glyph_result_t r;
        logic [7:0]    hi;
        logic [7:0]    lo;
        int            idx;
        r.glyph_src = SRC_BLANK;
        r.glyph_idx = '0;
        r.byte_off  = '0;
        hi = code[15:8];
        lo = code[7:0];
        if (code >= 16'h80A0)
        begin
            r.pix_width = 5'd16;
            if (hi >= 8'hB0 && hi <= 8'hF7 && lo >= 8'hA1 && lo <= 8'hFE)
            begin
                // Main font wins over the punctuation list, even for its last entry.
                idx = (int'(hi) - 'hB0) * 94 + (int'(lo) - 'hA1);
                r.glyph_src = SRC_MAIN;
                r.glyph_idx = 13'(idx);
                r.byte_off  = 18'(idx * WIDE_GLYPH_BYTES);
            end
            else
            begin
                for (int p = 0; p < PUNCT_SEARCH; p++)
                begin
                    if (r.glyph_src == SRC_BLANK && PUNCT_TABLE[p] == code)
                    begin
                        r.glyph_src = SRC_EXTRA;
                        r.glyph_idx = 13'(p);
                        r.byte_off  = 18'(p * WIDE_GLYPH_BYTES);
                    end
                end
            end
        end
        else
        begin
            r.pix_width = 5'd8;
            // An inverted range leaves every narrow code blank.
            if (code >= 16'(range_first) && code <= 16'(range_last))
            begin
                idx = int'(code) - int'(range_first);
                r.glyph_src = SRC_NARROW;
                r.glyph_idx = 13'(idx);
                r.byte_off  = 18'(idx * NARROW_GLYPH_BYTES);
            end
        end
        return r;
    endfunction

    // Gap length: mostly none or short, now and then a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pick a code, weighted toward the interesting corners of the code space.
    function automatic logic [15:0] random_code();
        int          roll;
        logic [7:0]  hi;
        logic [7:0]  lo;
        roll = $urandom_range(0, 99);
        if (roll < 22)
            return 16'($urandom_range(0, 127));
        if (roll < 30)
            return 16'($urandom_range(128, 'h809F));
        if (roll < 60)
        begin
            hi = 8'($urandom_range('hB0, 'hF7));
            lo = 8'($urandom_range('hA1, 'hFE));
            return {hi, lo};
        end
        if (roll < 75)
            return PUNCT_TABLE[$urandom_range(0, 29)];
        if (roll < 88)
        begin
            // Land on or just across a row or column border of the main font.
            case ($urandom_range(0, 3))
                0: hi = 8'hAF;
                1: hi = 8'hF8;
                2: hi = 8'hB0;
                default: hi = 8'hF7;
            endcase
            case ($urandom_range(0, 3))
                0: lo = 8'hA0;
                1: lo = 8'hFF;
                2: lo = 8'hA1;
                default: lo = 8'hFE;
            endcase
            return {hi, lo};
        end
        return 16'($urandom_range(0, 'hFFFF));
    endfunction

    // Offer one code, hold it until the transfer, then log its expected glyph.
    task automatic send_code(input logic [15:0] code, input int gap, input bit typed,
                             input glyph_result_t typed_result);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = code;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_glyphs.push_back(typed ? typed_result : locate_glyph(code));
        codes_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected glyph has come out.
    task automatic drain_glyphs();
        s_tvalid = 1'b0;
        while (pending_glyphs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one range register; call only with the pipeline empty.
    task automatic write_range(input logic [0:0] reg_sel, input logic [6:0] value);
        cfg_valid = 1'b1;
        cfg_index = reg_sel;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (reg_sel == REG_ASCII_FIRST)
            range_first = value;
        else
            range_last = value;
        config_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver back-pressure: random bursts of ready and stall.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (no_idle)
            m_tready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (m_tready && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 3);
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end
    end

    // Compare every output transfer against the oldest expected glyph.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_glyphs.size() == 0)
            begin
                $display("%0t: unexpected glyph, expected none, actual src %0d data %h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end
            else
            begin
                oldest_glyph = pending_glyphs.pop_front();
                source_hits[m_tuser]++;
                if (m_tuser != oldest_glyph.glyph_src)
                begin
                    $display("%0t: glyph_source expected %0d actual %0d",
                             $time, oldest_glyph.glyph_src, m_tuser);
                    error_count++;
                end
                if (m_tdata[12:0] != oldest_glyph.glyph_idx)
                begin
                    $display("%0t: glyph_index expected %0d actual %0d",
                             $time, oldest_glyph.glyph_idx, m_tdata[12:0]);
                    error_count++;
                end
                if (m_tdata[30:13] != oldest_glyph.byte_off)
                begin
                    $display("%0t: byte_offset expected %0d actual %0d",
                             $time, oldest_glyph.byte_off, m_tdata[30:13]);
                    error_count++;
                end
                if (m_tdata[35:31] != oldest_glyph.pix_width)
                begin
                    $display("%0t: glyph_width expected %0d actual %0d",
                             $time, oldest_glyph.pix_width, m_tdata[35:31]);
                    error_count++;
                end
            end
        end
    end

    // Directed rows, run under the reset range 0x20..0x7E.
    code_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'h0000, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd8}},
        '{16'h001F, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd8}},
        '{16'h0020, 1'b1, '{SRC_NARROW, 13'd0,    18'd0,      5'd8}},
        '{16'h007E, 1'b1, '{SRC_NARROW, 13'd94,   18'd1504,   5'd8}},
        '{16'h007F, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd8}},
        '{16'h809F, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd8}},
        '{16'h80A0, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd16}},
        '{16'hB0A1, 1'b1, '{SRC_MAIN,   13'd0,    18'd0,      5'd16}},
        '{16'hF7FE, 1'b1, '{SRC_MAIN,   13'd6767, 18'd216544, 5'd16}},
        '{16'hA1A2, 1'b1, '{SRC_EXTRA,  13'd0,    18'd0,      5'd16}},
        '{16'hA3BF, 1'b1, '{SRC_EXTRA,  13'd28,   18'd896,    5'd16}},
        '{16'hE0C5, 1'b1, '{SRC_MAIN,   13'd4548, 18'd145536, 5'd16}},
        '{16'hFFFF, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd16}},
        '{16'hB0A0, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd16}},
        '{16'hB0FF, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd16}},
        '{16'hAFA1, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd16}},
        '{16'hF8A1, 1'b1, '{SRC_BLANK,  13'd0,    18'd0,      5'd16}},
        '{16'h0041, 1'b0, '{SRC_BLANK,  13'd0,    18'd0,      5'd0}},
        '{16'h4141, 1'b0, '{SRC_BLANK,  13'd0,    18'd0,      5'd0}},
        '{16'hA1A1, 1'b0, '{SRC_BLANK,  13'd0,    18'd0,      5'd0}},
        '{16'hA1B9, 1'b0, '{SRC_BLANK,  13'd0,    18'd0,      5'd0}},
        '{16'hA3A1, 1'b0, '{SRC_BLANK,  13'd0,    18'd0,      5'd0}},
        '{16'hC0D0, 1'b0, '{SRC_BLANK,  13'd0,    18'd0,      5'd0}},
        '{16'h80A1, 1'b0, '{SRC_BLANK,  13'd0,    18'd0,      5'd0}}
    };

    initial
    begin
        logic [6:0] first_val;
        logic [6:0] last_val;
        // Every input known from time zero; hold reset once, at the start.
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ASCII_FIRST;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: corners of both paths under the reset range.
        foreach (directed_rows[i])
            send_code(directed_rows[i].code, idle_gap(), directed_rows[i].typed,
                      directed_rows[i].result);

        // Random part: one range setting per phase, extremes first.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_glyphs();
            case (phase)
                0:
                begin
                    first_val = 7'd0;
                    last_val  = 7'd127;
                end
                1:
                begin
                    first_val = 7'd127;
                    last_val  = 7'd0;
                end
                2:
                begin
                    first_val = 7'd0;
                    last_val  = 7'd0;
                end
                3:
                begin
                    first_val = 7'd127;
                    last_val  = 7'd127;
                end
                4:
                begin
                    first_val = ASCII_FIRST_RST;
                    last_val  = ASCII_LAST_RST;
                end
                default:
                begin
                    first_val = 7'($urandom_range(0, 127));
                    last_val  = 7'($urandom_range(0, 127));
                end
            endcase
            write_range(REG_ASCII_FIRST, first_val);
            write_range(REG_ASCII_LAST, last_val);
            // One phase runs back to back with the receiver always ready.
            no_idle = (phase == 5);
            for (int n = 0; n < CODES_PER_PHASE; n++)
            begin
                // Halfway through some phases, hold off until the output drains.
                if (n == CODES_PER_PHASE / 2 && phase % 2 == 0)
                begin
                    s_tvalid = 1'b0;
                    while (pending_glyphs.size() != 0)
                        @(negedge clk);
                end
                send_code(random_code(), idle_gap(), 1'b0,
                          '{SRC_BLANK, 13'd0, 18'd0, 5'd0});
            end
            no_idle = 1'b0;
        end

        // Let the last glyphs out, then watch a little longer for strays.
        drain_glyphs();
        repeat (10) @(posedge clk);
        if (pending_glyphs.size() != 0)
        begin
            $display("%0t: %0d glyphs expected but never seen",
                     $time, pending_glyphs.size());
            error_count++;
        end

        $display("Sent %0d codes over %0d range settings (%0d register writes).",
                 codes_sent, RANDOM_PHASES + 1, config_writes);
        $display("Glyphs seen: blank %0d, narrow %0d, main %0d, extension %0d.",
                 source_hits[0], source_hits[1], source_hits[2], source_hits[3]);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/gbgl_pkg.sv
hdl/gbgl_index.sv
hdl/gb2312_glyph_locator.sv
hdl/gbgl_checker.sv
tb/tb.sv
